// ===== sv/dra_pkg.sv =====
package dra_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 8;
   localparam int unsigned CSR_DATA_WIDTH = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_RECORDS = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REQUEST_LIMIT = 8'd1;

   localparam logic [7:0] MAX_RECORDS_RESET = 8'd8;
   localparam logic [15:0] REQUEST_LIMIT_RESET = 16'd16;

   localparam int unsigned RSP_DEPTH_DEFAULT = 4;

   localparam logic KIND_ADDRESS = 1'b0;
   localparam logic KIND_FINISHED = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [31:0] address;
      logic [7:0]  record_count;
      logic        run_end;
   } dra_result_type;

   typedef struct packed {
      logic [1:0]     count;
      dra_result_type first;
      dra_result_type second;
   } dra_push_type;

endpackage

// ===== sv/dns_reply_a_record_extractor.sv =====
// An accepted byte is held in the input register; its results are written into the result queue and offered from there.
// Throughput: one byte per cycle while the result queue has room; a byte that yields an address
// and the finished result at once pushes two entries into the single-read result queue.
// The input side stalls while that queue has fewer than two free entries.
// Synchronous active-high reset clears the parser state and the queue and restores
// max_records to 8 and request_limit to 16.
module dns_reply_a_record_extractor #(
   parameter int unsigned RSP_DEPTH = dra_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_data_byte,
   input  logic [15:0]                         req_packet_length,
   input  logic                                req_final_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_kind,
   output logic [31:0]                         rsp_address,
   output logic [7:0]                          rsp_record_count,
   output logic                                rsp_run_end,
   input  logic                                csr_write_enable,
   input  logic [dra_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [dra_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import dra_pkg::*;

   dra_push_type   push;
   dra_result_type rsp_result;
   logic           room;

   dra_parser u_parser (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_packet_length (req_packet_length),
      .req_final_byte    (req_final_byte),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .room              (room),
      .push              (push)
   );

   dra_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   assign rsp_kind = rsp_result.kind;
   assign rsp_address = rsp_result.address;
   assign rsp_record_count = rsp_result.record_count;
   assign rsp_run_end = rsp_result.run_end;

endmodule

// ===== sv/dra_rsp_fifo.sv =====
module dra_rsp_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dra_pkg::dra_push_type   push,
   output logic                    room,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output dra_pkg::dra_result_type rsp_result
);
   import dra_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(DEPTH - 2);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   dra_result_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_next;
   logic [CNT_W-1:0] count_ff, count_in;
   logic pop;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      ptr_inc = (p == LAST) ? '0 : p + PTR_W'(1);
   endfunction

   assign rsp_valid = count_ff != '0;
   assign rsp_result = mem_ff[rd_ptr_ff];
   assign room = count_ff <= ROOM_MAX;
   assign pop = rsp_valid && rsp_ready;
   assign wr_next = ptr_inc(wr_ptr_ff);

   always_comb begin
      count_in = count_ff + CNT_W'(push.count) - CNT_W'(pop);
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      case (push.count)
         2'd1: wr_ptr_in = wr_next;
         2'd2: wr_ptr_in = ptr_inc(wr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

endmodule

// ===== sv/dra_parser.sv =====
module dra_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_data_byte,
   input  logic [15:0]                         req_packet_length,
   input  logic                                req_final_byte,
   input  logic                                csr_write_enable,
   input  logic [dra_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [dra_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   input  logic                                room,
   output dra_pkg::dra_push_type               push
);
   import dra_pkg::*;

   typedef enum logic [3:0] {
      PH_HEADER, PH_QFIRST, PH_QCHECK, PH_QSCAN, PH_QSKIP, PH_NAME, PH_NAMESKIP,
      PH_PTR2, PH_TYPEHI, PH_TYPELO, PH_FIXED, PH_LENHI, PH_LENLO, PH_ADDR, PH_DATA
   } phase_type;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  byte_ff;
   logic [15:0] len_ff;
   logic        fin_ff;
   logic [7:0]  max_records_ff;
   logic [15:0] request_limit_ff;

   phase_type   phase_ff, phase_in;
   logic [15:0] pos_ff, pos_in;
   logic        hv_ff, hv_in;
   logic [15:0] answers_ff, answers_in;
   logic [15:0] skip_ff, skip_in;
   logic [31:0] acc_ff, acc_in;
   logic [15:0] rtype_ff, rtype_in;
   logic [15:0] rdl_ff, rdl_in;
   logic [7:0]  found_ff, found_in;
   logic        stopped_ff, stopped_in;

   logic        fire, accept, addr_hit, in_range, rec_stop;
   logic [15:0] hdr_acc, skip_dec, ans_dec, rdl_new;
   logic [17:0] pos18, next18, len18;
   logic [31:0] addr_acc;
   logic [7:0]  cap;
   dra_result_type addr_res, fin_res;

   assign fire = in_valid_ff && room;
   assign req_ready = !in_valid_ff || room;
   assign accept = req_valid && req_ready;
   assign in_valid_in = accept || (in_valid_ff && !fire);

   always_comb begin
      pos18 = {2'b00, pos_ff};
      next18 = pos18 + 18'd1;
      len18 = {2'b00, len_ff};
      hdr_acc = {acc_ff[7:0], byte_ff};
      in_range = (hdr_acc != 16'd0) && (hdr_acc <= request_limit_ff);
      skip_dec = skip_ff - 16'd1;
      ans_dec = (answers_ff != 16'd0) ? answers_ff - 16'd1 : 16'd0;
      rec_stop = (next18 + 18'd6) >= len18;
      rdl_new = {rdl_ff[15:8], rdl_ff[7:0] | byte_ff};
      addr_acc = {acc_ff[23:0], byte_ff};
      cap = (max_records_ff == 8'd0) ? 8'd255 : max_records_ff - 8'd1;
      addr_hit = 1'b0;

      phase_in = phase_ff;
      pos_in = pos_ff;
      hv_in = hv_ff;
      answers_in = answers_ff;
      skip_in = skip_ff;
      acc_in = acc_ff;
      rtype_in = rtype_ff;
      rdl_in = rdl_ff;
      found_in = found_ff;
      stopped_in = stopped_ff;

      if (fire && !stopped_ff) begin
         case (phase_ff)
            PH_HEADER: begin
               acc_in = {16'd0, hdr_acc};
               if (pos_ff == 16'd3) begin
                  hv_in = hdr_acc[15];
               end else if (pos_ff == 16'd5) begin
                  if (hdr_acc > request_limit_ff) hv_in = 1'b0;
               end else if (pos_ff == 16'd7) begin
                  answers_in = hdr_acc;
                  rtype_in = {15'd0, in_range};
               end else if (pos_ff == 16'd9) begin
                  if (in_range) rtype_in = 16'd1;
               end else if (pos_ff >= 16'd11) begin
                  hv_in = hv_ff && ((rtype_ff != 16'd0) || in_range) && (len_ff > 16'd12);
                  rtype_in = 16'd0;
                  acc_in = 32'd0;
                  if (hv_in) phase_in = PH_QFIRST;
                  else stopped_in = 1'b1;
               end
            end
            PH_QFIRST: phase_in = PH_QCHECK;
            PH_QCHECK: begin
               if (byte_ff == 8'd0) begin
                  skip_in = 16'd3;
                  phase_in = PH_QSKIP;
               end else begin
                  phase_in = PH_QSCAN;
               end
            end
            PH_QSCAN: begin
               if (pos_ff >= len_ff) begin
                  stopped_in = 1'b1;
               end else if (byte_ff == 8'd0) begin
                  skip_in = 16'd4;
                  phase_in = PH_QSKIP;
               end
            end
            PH_QSKIP: begin
               skip_in = skip_dec;
               if (skip_dec == 16'd0) begin
                  if (answers_ff == 16'd0 || rec_stop) begin
                     stopped_in = 1'b1;
                  end else begin
                     phase_in = PH_NAME;
                     acc_in = 32'd0;
                  end
               end
            end
            PH_NAME: begin
               if (byte_ff == 8'h00) begin
                  phase_in = PH_TYPEHI;
               end else if (byte_ff == 8'hC0) begin
                  phase_in = PH_PTR2;
               end else if (byte_ff == 8'hFF) begin
                  if (acc_ff == 32'd0) begin
                     stopped_in = 1'b1;
                  end else begin
                     rtype_in = 16'hFF00;
                     phase_in = PH_TYPELO;
                  end
               end else begin
                  skip_in = {8'd0, byte_ff};
                  acc_in = 32'd1;
                  phase_in = PH_NAMESKIP;
               end
            end
            PH_NAMESKIP: begin
               skip_in = skip_dec;
               if (skip_dec == 16'd0) phase_in = PH_NAME;
            end
            PH_PTR2: phase_in = PH_TYPEHI;
            PH_TYPEHI: begin
               rtype_in = {byte_ff, 8'd0};
               phase_in = PH_TYPELO;
            end
            PH_TYPELO: begin
               rtype_in = {rtype_ff[15:8], rtype_ff[7:0] | byte_ff};
               skip_in = 16'd6;
               phase_in = PH_FIXED;
            end
            PH_FIXED: begin
               skip_in = skip_dec;
               if (skip_dec == 16'd0) phase_in = PH_LENHI;
            end
            PH_LENHI: begin
               rdl_in = {byte_ff, 8'd0};
               phase_in = PH_LENLO;
            end
            PH_LENLO: begin
               rdl_in = rdl_new;
               if (rdl_new <= 16'd1 || ({2'b00, rdl_new} + next18) > len18) begin
                  stopped_in = 1'b1;
               end else if (rtype_ff == 16'd1 && rdl_new == 16'd4) begin
                  acc_in = 32'd0;
                  skip_in = 16'd4;
                  phase_in = PH_ADDR;
               end else begin
                  skip_in = rdl_new;
                  phase_in = PH_DATA;
               end
            end
            PH_ADDR: begin
               acc_in = addr_acc;
               skip_in = skip_dec;
               if (skip_dec == 16'd0) begin
                  if (addr_acc != 32'hFFFF_FFFF) begin
                     if (found_ff < cap) begin
                        found_in = found_ff + 8'd1;
                        addr_hit = 1'b1;
                     end else begin
                        stopped_in = 1'b1;
                     end
                  end
                  if (!stopped_in) begin
                     answers_in = ans_dec;
                     if (ans_dec == 16'd0 || rec_stop) begin
                        stopped_in = 1'b1;
                     end else begin
                        phase_in = PH_NAME;
                        acc_in = 32'd0;
                     end
                  end
               end
            end
            PH_DATA: begin
               skip_in = skip_dec;
               if (skip_dec == 16'd0) begin
                  answers_in = ans_dec;
                  if (ans_dec == 16'd0 || rec_stop) begin
                     stopped_in = 1'b1;
                  end else begin
                     phase_in = PH_NAME;
                     acc_in = 32'd0;
                  end
               end
            end
            default: stopped_in = 1'b1;
         endcase
      end

      addr_res = '{kind: KIND_ADDRESS, address: addr_acc, record_count: found_in,
                   run_end: 1'b0};
      fin_res = '{kind: KIND_FINISHED, address: 32'd0, record_count: found_in,
                  run_end: 1'b1};

      if (fire) begin
         if (pos_ff != 16'hFFFF) pos_in = pos_ff + 16'd1;
         if (fin_ff) begin
            pos_in = 16'd0;
            phase_in = PH_HEADER;
            hv_in = 1'b0;
            answers_in = 16'd0;
            skip_in = 16'd0;
            acc_in = 32'd0;
            rtype_in = 16'd0;
            rdl_in = 16'd0;
            found_in = 8'd0;
            stopped_in = 1'b0;
         end
      end

      push.first = addr_hit ? addr_res : fin_res;
      push.second = fin_res;
      push.count = fire ? (2'({1'b0, addr_hit}) + 2'({1'b0, fin_ff})) : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         max_records_ff <= MAX_RECORDS_RESET;
         request_limit_ff <= REQUEST_LIMIT_RESET;
         phase_ff <= PH_HEADER;
         pos_ff <= '0;
         hv_ff <= 1'b0;
         answers_ff <= '0;
         skip_ff <= '0;
         acc_ff <= '0;
         rtype_ff <= '0;
         rdl_ff <= '0;
         found_ff <= '0;
         stopped_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_write_enable && csr_index == CSR_MAX_RECORDS) begin
            max_records_ff <= csr_write_data[7:0];
         end
         if (csr_write_enable && csr_index == CSR_REQUEST_LIMIT) begin
            request_limit_ff <= csr_write_data[15:0];
         end
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         hv_ff <= hv_in;
         answers_ff <= answers_in;
         skip_ff <= skip_in;
         acc_ff <= acc_in;
         rtype_ff <= rtype_in;
         rdl_ff <= rdl_in;
         found_ff <= found_in;
         stopped_ff <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_data_byte;
         len_ff <= req_packet_length;
         fin_ff <= req_final_byte;
      end
   end

endmodule

// ===== sv/dra_checker.sv =====
module dra_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [7:0]                          req_data_byte,
   input logic [15:0]                         req_packet_length,
   input logic                                req_final_byte,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_kind,
   input logic [31:0]                         rsp_address,
   input logic [7:0]                          rsp_record_count,
   input logic                                rsp_run_end,
   input logic                                csr_write_enable,
   input logic [dra_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input logic [dra_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   // The queue is empty in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result queue not empty after reset");

   // A finished item and only a finished item closes the message.
   a_end_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_run_end == rsp_kind))
      else $error("run_end does not match kind");

   // An address item never carries the all-ones address or a zero count.
   a_addr_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind |-> rsp_address != 32'hFFFF_FFFF && rsp_record_count != 8'd0)
      else $error("bad address item");

   // A finished item reports no address.
   a_fin_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_address == 32'd0)
      else $error("finished item with an address");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_address)
         && $stable(rsp_kind) && $stable(rsp_record_count))
      else $error("stalled result changed");

endmodule

bind dns_reply_a_record_extractor dra_checker u_dra_checker (.*);

// ===== test/tb_dns_reply_a_record_extractor.sv =====
module tb_dns_reply_a_record_extractor;
   timeunit 1ns;
   timeprecision 1ps;

   import dra_pkg::*;

   class dns_answer_tracker;
      typedef enum logic [3:0] {
         WALK_HEADER, WALK_QFIRST, WALK_QCHECK, WALK_QSCAN, WALK_QSKIP, WALK_NAME,
         WALK_NAME_SKIP, WALK_POINTER, WALK_TYPE_HI, WALK_TYPE_LO, WALK_FIXED,
         WALK_LENGTH_HI, WALK_LENGTH_LO, WALK_ADDRESS, WALK_DATA
      } walk_phase_e;

      logic [7:0]     max_records;
      logic [15:0]    request_limit;
      logic [15:0]    position;
      walk_phase_e    phase;
      bit             header_ok;
      logic [15:0]    answers_left;
      logic [15:0]    skip_left;
      logic [31:0]    accumulator;
      logic [15:0]    record_type;
      logic [15:0]    data_length;
      logic [7:0]     found;
      bit             stopped;
      dra_result_type expected_answers[$];
      int             failures;
      int             answers_predicted;
      int             bytes_walked;

      function new();
         max_records = MAX_RECORDS_RESET;
         request_limit = REQUEST_LIMIT_RESET;
         failures = 0;
         answers_predicted = 0;
         bytes_walked = 0;
         clear_message();
      endfunction

      function void clear_message();
         position = 16'd0;
         phase = WALK_HEADER;
         header_ok = 1'b0;
         answers_left = 16'd0;
         skip_left = 16'd0;
         accumulator = 32'd0;
         record_type = 16'd0;
         data_length = 16'd0;
         found = 8'd0;
         stopped = 1'b0;
      endfunction

      function int pending();
         return expected_answers.size();
      endfunction

      function void add_answer(logic kind, logic [31:0] address, logic [7:0] count,
                               logic run_end);
         dra_result_type entry;
         entry.kind = kind;
         entry.address = address;
         entry.record_count = count;
         entry.run_end = run_end;
         expected_answers.push_back(entry);
         answers_predicted++;
      endfunction

      function bit count_fits(logic [31:0] count);
         return count >= 1 && count <= request_limit;
      endfunction

      function void begin_record(int unsigned next, int unsigned length);
         if (answers_left == 0 || next + 6 >= length) begin
            stopped = 1'b1;
         end else begin
            phase = WALK_NAME;
            accumulator = 32'd0;
         end
      endfunction

      function void end_record(int unsigned next, int unsigned length);
         if (answers_left > 0)
            answers_left--;
         begin_record(next, length);
      endfunction

      function void walk_byte(logic [7:0] value, int unsigned pos, int unsigned length);
         int unsigned capacity;
         case (phase)
            WALK_HEADER: begin
               accumulator = {16'd0, accumulator[7:0], value};
               if (pos == 3) begin
                  header_ok = accumulator[15];
               end else if (pos == 5) begin
                  if (accumulator > request_limit)
                     header_ok = 1'b0;
               end else if (pos == 7) begin
                  answers_left = accumulator[15:0];
                  record_type = count_fits(accumulator) ? 16'd1 : 16'd0;
               end else if (pos == 9) begin
                  if (count_fits(accumulator))
                     record_type = 16'd1;
               end else if (pos >= 11) begin
                  if (count_fits(accumulator))
                     record_type = 16'd1;
                  header_ok = header_ok && record_type != 0 && length > 12;
                  record_type = 16'd0;
                  accumulator = 32'd0;
                  if (header_ok)
                     phase = WALK_QFIRST;
                  else
                     stopped = 1'b1;
               end
            end
            WALK_QFIRST: phase = WALK_QCHECK;
            WALK_QCHECK: begin
               if (value == 8'h00) begin
                  skip_left = 16'd3;
                  phase = WALK_QSKIP;
               end else begin
                  phase = WALK_QSCAN;
               end
            end
            WALK_QSCAN: begin
               if (pos >= length) begin
                  stopped = 1'b1;
               end else if (value == 8'h00) begin
                  skip_left = 16'd4;
                  phase = WALK_QSKIP;
               end
            end
            WALK_QSKIP: begin
               skip_left--;
               if (skip_left == 0)
                  begin_record(pos + 1, length);
            end
            WALK_NAME: begin
               if (value == 8'h00) begin
                  phase = WALK_TYPE_HI;
               end else if (value == 8'hC0) begin
                  phase = WALK_POINTER;
               end else if (value == 8'hFF) begin
                  if (accumulator == 0) begin
                     stopped = 1'b1;
                  end else begin
                     record_type = 16'hFF00;
                     phase = WALK_TYPE_LO;
                  end
               end else begin
                  skip_left = {8'd0, value};
                  accumulator = 32'd1;
                  phase = WALK_NAME_SKIP;
               end
            end
            WALK_NAME_SKIP: begin
               skip_left--;
               if (skip_left == 0)
                  phase = WALK_NAME;
            end
            WALK_POINTER: phase = WALK_TYPE_HI;
            WALK_TYPE_HI: begin
               record_type = {value, 8'd0};
               phase = WALK_TYPE_LO;
            end
            WALK_TYPE_LO: begin
               record_type = {record_type[15:8], value};
               skip_left = 16'd6;
               phase = WALK_FIXED;
            end
            WALK_FIXED: begin
               skip_left--;
               if (skip_left == 0)
                  phase = WALK_LENGTH_HI;
            end
            WALK_LENGTH_HI: begin
               data_length = {value, 8'd0};
               phase = WALK_LENGTH_LO;
            end
            WALK_LENGTH_LO: begin
               data_length = {data_length[15:8], value};
               if (data_length <= 1 || data_length + pos + 1 > length) begin
                  stopped = 1'b1;
               end else if (record_type == 16'd1 && data_length == 16'd4) begin
                  accumulator = 32'd0;
                  skip_left = 16'd4;
                  phase = WALK_ADDRESS;
               end else begin
                  skip_left = data_length;
                  phase = WALK_DATA;
               end
            end
            WALK_ADDRESS: begin
               accumulator = {accumulator[23:0], value};
               skip_left--;
               if (skip_left == 0) begin
                  if (accumulator != 32'hFFFF_FFFF) begin
                     capacity = (max_records == 0) ? 255 : max_records - 1;
                     if (found < capacity) begin
                        found++;
                        add_answer(KIND_ADDRESS, accumulator, found, 1'b0);
                     end else begin
                        stopped = 1'b1;
                     end
                  end
                  if (!stopped)
                     end_record(pos + 1, length);
               end
            end
            WALK_DATA: begin
               skip_left--;
               if (skip_left == 0)
                  end_record(pos + 1, length);
            end
            default: stopped = 1'b1;
         endcase
      endfunction

      function void take_request_byte(logic [7:0] value, logic [15:0] length, logic last);
         if (!stopped) begin
            bytes_walked++;
            walk_byte(value, position, length);
         end
         if (position != 16'hFFFF)
            position++;
         if (last) begin
            add_answer(KIND_FINISHED, 32'd0, found, 1'b1);
            clear_message();
         end
      endfunction

      task report(string text);
         failures++;
         if (failures <= 100)
            $display("mismatch: %s", text);
      endtask

      task check_response(logic kind, logic [31:0] address, logic [7:0] count,
                          logic run_end);
         dra_result_type want;
         if (expected_answers.size() == 0) begin
            report($sformatf("unexpected result kind %0b address %h count %0d",
                             kind, address, count));
            return;
         end
         want = expected_answers.pop_front();
         if (kind !== want.kind)
            report($sformatf("kind %0b, expected %0b", kind, want.kind));
         if (address !== want.address)
            report($sformatf("address %h, expected %h", address, want.address));
         if (count !== want.record_count)
            report($sformatf("record_count %0d, expected %0d", count, want.record_count));
         if (run_end !== want.run_end)
            report($sformatf("run_end %0b, expected %0b", run_end, want.run_end));
      endtask

      task report_leftovers();
         if (expected_answers.size() != 0)
            report($sformatf("%0d results never arrived", expected_answers.size()));
      endtask
   endclass

   typedef enum int {
      NAME_POINTER, NAME_ROOT, NAME_LABELS, NAME_LABELS_POINTER, NAME_WIDE_LABEL,
      NAME_FF_FIRST, NAME_FF_AFTER_LABEL
   } name_form_e;

   localparam logic [15:0] TYPE_A = 16'd1;
   localparam logic [15:0] TYPE_CNAME = 16'd5;
   localparam logic [15:0] CLASS_IN = 16'd1;
   localparam logic [15:0] FLAG_REPLY = 16'h8000;
   localparam int HOLD_OFF_CYCLES = 300;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [7:0]                 req_data_byte;
   logic [15:0]                req_packet_length;
   logic                       req_final_byte;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic                       rsp_kind;
   logic [31:0]                rsp_address;
   logic [7:0]                 rsp_record_count;
   logic                       rsp_run_end;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   dns_answer_tracker tracker = new();
   logic [7:0]        message[$];
   int                sender_idle_pct = 0;
   int                receiver_idle_pct = 0;
   int                hold_asked = 0;

   dns_reply_a_record_extractor dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_packet_length (req_packet_length),
      .req_final_byte    (req_final_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_address       (rsp_address),
      .rsp_record_count  (rsp_record_count),
      .rsp_run_end       (rsp_run_end),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("tb_dns_reply_a_record_extractor NOT OK");
      $finish;
   end

   function automatic void push_word(logic [15:0] word);
      message.push_back(word[15:8]);
      message.push_back(word[7:0]);
   endfunction

   function automatic void add_header(logic [15:0] flags, logic [15:0] queries,
                                      logic [15:0] answers, logic [15:0] authorities,
                                      logic [15:0] additionals);
      message.delete();
      push_word($urandom_range(16'hFFFF));
      push_word(flags);
      push_word(queries);
      push_word(answers);
      push_word(authorities);
      push_word(additionals);
   endfunction

   function automatic void add_labels();
      int unsigned chars;
      repeat ($urandom_range(1, 2)) begin
         chars = $urandom_range(1, 8);
         message.push_back(chars);
         repeat (chars) message.push_back($urandom_range(255));
      end
   endfunction

   function automatic void add_question(bit root);
      int unsigned chars;
      if (root) begin
         message.push_back(8'h00);
      end else begin
         repeat ($urandom_range(1, 2)) begin
            chars = $urandom_range(1, 8);
            message.push_back(chars);
            repeat (chars) message.push_back($urandom_range(1, 255));
         end
         message.push_back(8'h00);
      end
      push_word(TYPE_A);
      push_word(CLASS_IN);
   endfunction

   function automatic void add_name(name_form_e form);
      int unsigned chars;
      case (form)
         NAME_POINTER: begin
            message.push_back(8'hC0);
            message.push_back($urandom_range(255));
         end
         NAME_ROOT: message.push_back(8'h00);
         NAME_LABELS: begin
            add_labels();
            message.push_back(8'h00);
         end
         NAME_LABELS_POINTER: begin
            add_labels();
            message.push_back(8'hC0);
            message.push_back($urandom_range(255));
         end
         NAME_WIDE_LABEL: begin
            chars = $urandom_range(8'hC1, 8'hFE);
            message.push_back(chars);
            repeat (chars) message.push_back($urandom_range(255));
            message.push_back(8'h00);
         end
         NAME_FF_FIRST: message.push_back(8'hFF);
         default: begin
            message.push_back(8'd1);
            message.push_back($urandom_range(255));
            message.push_back(8'hFF);
         end
      endcase
   endfunction

   function automatic void add_record(name_form_e form, logic [15:0] rtype,
                                      logic [15:0] rdlen, logic [31:0] address);
      add_name(form);
      push_word(rtype);
      push_word(CLASS_IN);
      push_word($urandom_range(16'hFFFF));
      push_word($urandom_range(16'hFFFF));
      push_word(rdlen);
      if (rtype == TYPE_A && rdlen == 16'd4) begin
         for (int i = 3; i >= 0; i--) message.push_back(address[8*i +: 8]);
      end else begin
         for (int i = 0; i < rdlen && i < 16; i++) message.push_back($urandom_range(255));
      end
   endfunction

   function automatic name_form_e random_name_form();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 40) return NAME_POINTER;
      if (pick < 55) return NAME_ROOT;
      if (pick < 75) return NAME_LABELS;
      if (pick < 90) return NAME_LABELS_POINTER;
      if (pick < 94) return NAME_WIDE_LABEL;
      if (pick < 97) return NAME_FF_FIRST;
      return NAME_FF_AFTER_LABEL;
   endfunction

   function automatic logic [31:0] random_address();
      if ($urandom_range(99) < 8)
         return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   function automatic void add_random_record();
      int unsigned pick;
      logic [15:0] bad_length;
      pick = $urandom_range(99);
      if (pick < 70) begin
         add_record(random_name_form(), TYPE_A, 16'd4, random_address());
      end else if (pick < 80) begin
         add_record(random_name_form(), TYPE_A, $urandom_range(2, 8), 32'd0);
      end else if (pick < 95) begin
         add_record(random_name_form(), $urandom_range(2, 16'hFFFF), $urandom_range(2, 12),
                    32'd0);
      end else begin
         bad_length = ($urandom_range(1) == 0) ? $urandom_range(1)
                                               : $urandom_range(17, 16'hFFFF);
         add_record(random_name_form(), TYPE_A, bad_length, 32'd0);
      end
   endfunction

   function automatic void build_random_message();
      int unsigned records;
      int unsigned limit;
      logic [15:0] flags;
      logic [15:0] queries;
      logic [15:0] answers;
      int unsigned cut;
      if ($urandom_range(99) < 10) begin
         message.delete();
         repeat ($urandom_range(1, 30)) message.push_back($urandom_range(255));
         return;
      end
      records = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5);
      limit = tracker.request_limit;
      flags = $urandom_range(16'hFFFF);
      flags = ($urandom_range(99) < 90) ? (flags | FLAG_REPLY) : (flags & ~FLAG_REPLY);
      queries = ($urandom_range(99) < 85) ? $urandom_range(0, (limit < 3) ? limit : 3)
                                          : $urandom_range(16'hFFFF);
      answers = ($urandom_range(99) < 85) ? records : $urandom_range(16'hFFFF);
      add_header(flags, queries, answers, $urandom_range(1),
                 ($urandom_range(4) == 0) ? $urandom_range(16'hFFFF) : $urandom_range(1));
      add_question($urandom_range(1));
      repeat (records) add_random_record();
      cut = $urandom_range(99);
      if (cut < 8) begin
         cut = $urandom_range(1, message.size());
         while (message.size() > cut) message.delete(message.size() - 1);
      end else if (cut < 15) begin
         message[$urandom_range(message.size() - 1)] = $urandom_range(255);
      end
   endfunction

   function automatic logic [15:0] pick_length();
      int unsigned size;
      int unsigned pick;
      size = message.size();
      pick = $urandom_range(99);
      if (pick < 80) return size;
      if (pick < 85) return size + $urandom_range(1, 100);
      if (pick < 90) return $urandom_range(16'hFFFF);
      if (pick < 95) return (size > 1) ? $urandom_range(1, size - 1) : size;
      return 16'hFFFF;
   endfunction

   function automatic void build_bulk_reply(int unsigned count);
      add_header(FLAG_REPLY, 16'd0, count, 16'd1, 16'd0);
      add_question(1'b1);
      repeat (count) add_record(NAME_POINTER, TYPE_A, 16'd4, $urandom_range(32'hFFFF_FFFE));
   endfunction

   task automatic send_byte(logic [7:0] value, logic [15:0] length, logic last);
      int gap;
      gap = 0;
      while (gap < 8 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         gap++;
      end
      req_valid <= 1'b1;
      req_data_byte <= value;
      req_packet_length <= length;
      req_final_byte <= last;
      do @(posedge clock); while (req_ready !== 1'b1);
      tracker.take_request_byte(value, length, last);
   endtask

   task automatic send_message(logic [15:0] length);
      for (int i = 0; i < message.size(); i++)
         send_byte(message[i], length, i == message.size() - 1);
   endtask

   task automatic wait_for_idle();
      int waited;
      req_valid <= 1'b0;
      for (waited = 0; waited < 20000 && tracker.pending() != 0; waited++)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_settings(logic [7:0] max_value, logic [15:0] limit_value);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_MAX_RECORDS;
      csr_write_data <= {8'd0, max_value};
      @(posedge clock);
      csr_index <= CSR_REQUEST_LIMIT;
      csr_write_data <= limit_value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tracker.max_records = max_value;
      tracker.request_limit = limit_value;
   endtask

   task automatic run_directed();
      message.delete();
      repeat (5) message.push_back($urandom_range(255));
      send_message(16'd5);

      add_header(FLAG_REPLY | 16'h0180, 16'd1, 16'd4, 16'd0, 16'd0);
      add_question(1'b0);
      add_record(NAME_POINTER, TYPE_A, 16'd4, 32'h0000_0000);
      add_record(NAME_LABELS, TYPE_CNAME, 16'd6, 32'd0);
      add_record(NAME_ROOT, TYPE_A, 16'd4, 32'hFFFF_FFFF);
      add_record(NAME_LABELS_POINTER, TYPE_A, 16'd4, 32'hFFFF_FFFE);
      send_message(message.size());

      add_header(16'h7FFF, 16'd0, 16'd1, 16'd0, 16'd0);
      add_question(1'b1);
      add_record(NAME_POINTER, TYPE_A, 16'd4, $urandom);
      send_message(message.size());

      add_header(FLAG_REPLY, 16'd17, 16'd1, 16'd0, 16'd0);
      add_question(1'b1);
      add_record(NAME_POINTER, TYPE_A, 16'd4, $urandom);
      send_message(message.size());

      add_header(FLAG_REPLY, 16'd0, 16'd0, 16'd1, 16'd0);
      add_question(1'b1);
      add_record(NAME_POINTER, TYPE_A, 16'd4, $urandom);
      send_message(message.size());

      add_header(FLAG_REPLY, 16'd16, 16'd17, 16'd0, 16'd16);
      add_question(1'b0);
      add_record(NAME_POINTER, TYPE_A, 16'd4, $urandom);
      add_record(NAME_LABELS, TYPE_A, 16'd4, $urandom);
      send_message(message.size());

      add_header(FLAG_REPLY, 16'd0, 16'd1, 16'd0, 16'd0);
      add_question(1'b1);
      add_record(NAME_POINTER, TYPE_A, 16'd4, $urandom);
      send_message(16'd12);

      for (int form = NAME_WIDE_LABEL; form <= NAME_FF_AFTER_LABEL; form++) begin
         add_header(FLAG_REPLY, 16'd0, 16'd2, 16'd0, 16'd0);
         add_question(1'b1);
         add_record(name_form_e'(form), TYPE_A, 16'd4, $urandom);
         add_record(NAME_POINTER, TYPE_A, 16'd4, $urandom);
         send_message(message.size());
      end

      add_header(FLAG_REPLY, 16'd0, 16'd2, 16'd0, 16'd0);
      add_question(1'b1);
      add_record(NAME_POINTER, TYPE_A, 16'd1, 32'd0);
      add_record(NAME_POINTER, TYPE_A, 16'd4, $urandom);
      send_message(message.size());

      add_header(FLAG_REPLY, 16'd0, 16'd2, 16'd0, 16'd0);
      add_question(1'b1);
      add_record(NAME_POINTER, TYPE_CNAME, 16'd40, 32'd0);
      send_message(message.size());

      add_header(FLAG_REPLY, 16'd0, 16'd1, 16'd0, 16'd0);
      message.push_back(8'd3);
      repeat (20) message.push_back($urandom_range(1, 255));
      send_message(16'd16);

      add_header(FLAG_REPLY, 16'd0, 16'd2, 16'd0, 16'd0);
      add_question(1'b1);
      add_record(NAME_POINTER, TYPE_A, 16'd4, $urandom);
      send_message(16'd23);

      build_bulk_reply(9);
      send_message(message.size());

      build_bulk_reply(3);
      while (message.size() > 40) message.delete(message.size() - 1);
      send_message(16'd65);
   endtask

   initial begin : response_side
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1)
            tracker.check_response(rsp_kind, rsp_address, rsp_record_count, rsp_run_end);
         if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   initial begin : request_side
      int walked_start;
      int answers_start;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data_byte <= 8'd0;
      req_packet_length <= 16'd0;
      req_final_byte <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_MAX_RECORDS;
      csr_write_data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 36;
      receiver_idle_pct = 76;
      run_directed();

      for (int p = 0; p < 6; p++) begin
         wait_for_idle();
         case (p)
            0: write_settings(8'd8, 16'd16);
            1: write_settings(8'd1, 16'd0);
            2: write_settings(8'd255, 16'hFFFF);
            3: write_settings(8'd2, 16'd1);
            4: write_settings(8'd0, 16'hFFFF);
            default: write_settings(8'd200, 16'd3);
         endcase
         sender_idle_pct = (p < 2) ? 36 : (p < 4) ? 76 : 0;
         receiver_idle_pct = (p < 2) ? 76 : (p < 4) ? 36 : 0;

         // The receiver holds off while a reply full of addresses is offered.
         hold_asked++;
         build_bulk_reply(6);
         send_message(message.size());
         if (tracker.request_limit == 16'hFFFF) begin
            build_bulk_reply(260);
            send_message(message.size());
         end

         walked_start = tracker.bytes_walked;
         answers_start = tracker.answers_predicted;
         while (tracker.bytes_walked - walked_start < 75 ||
                tracker.answers_predicted - answers_start < 12) begin
            build_random_message();
            send_message(pick_length());
         end
      end

      // A question name that never ends runs the byte position up to saturation.
      add_header(FLAG_REPLY, 16'd0, 16'd1, 16'd0, 16'd0);
      message.push_back(8'd5);
      repeat (65600 - 13) message.push_back($urandom_range(1, 255));
      send_message(16'hFFFF);

      wait_for_idle();
      tracker.report_leftovers();
      if (tracker.failures == 0)
         $display("tb_dns_reply_a_record_extractor OK");
      else
         $display("tb_dns_reply_a_record_extractor NOT OK");
      $finish;
   end

endmodule
